### design/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants of the dusk/dawn light sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

    localparam int unsigned MODE_W  = 3;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned DELAY_W = 8;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_DISABLED  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WATCHING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OFF_DELAY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DARK      = 3'd4;

    localparam logic [CIDX_W-1:0] REG_ENABLED      = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ON_DELAY     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_OFF_DELAY    = 2'd2;
    localparam logic [CIDX_W-1:0] REG_ON_DURATION  = 2'd3;

    typedef struct packed {
        logic [DELAY_W-1:0] on_delay;
        logic [DELAY_W-1:0] off_delay;
        logic [TIMER_W-1:0] on_duration;
    } t_cfg;

    typedef struct packed {
        logic force_mode;
        logic enable;
    } t_mode_force;

endpackage

`default_nettype wire

### design/dds_if.sv
// ----------------------------------------------------------------------------
// dds_if
// Valid/ready channels of the sequencer: tick input, result, register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dds_item_if;
    logic valid;
    logic ready;
    logic is_dark;
    modport source (output valid, output is_dark, input ready);
    modport sink   (input valid, input is_dark, output ready);
endinterface

interface dds_result_if;
    logic                         valid;
    logic                         ready;
    logic                         lights_on;
    logic [dds_pkg::MODE_W-1:0]   mode_now;
    modport source (output valid, output lights_on, output mode_now, input ready);
    modport sink   (input valid, input lights_on, input mode_now, output ready);
endinterface

interface dds_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dds_pkg::CIDX_W-1:0]   index;
    logic [dds_pkg::CDATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/dusk_dawn_light_sequencer.sv
// ----------------------------------------------------------------------------
// dusk_dawn_light_sequencer
// Night-light sequencer advanced by minute ticks carrying a dark-sensor bit.
// ----------------------------------------------------------------------------
//  channel   | role   | payload
//  s_in      | sink   | is_dark
//  m_out     | source | lights_on, mode_now
//  s_cfg     | sink   | index, data (always ready)
//
//  One tick per cycle while the output is not stalled.
//  The tick register feeds the mode/timer update, whose result is registered.
//  Reset: mode watching, timer zero, all delay registers zero.
//  Output stall holds the result and the tick register; input ready drops
//  only while both are full and the output is not taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dusk_dawn_light_sequencer (
    input  wire             i_clk,
    input  wire             i_rst_n,
    dds_item_if.sink        s_in,
    dds_result_if.source    m_out,
    dds_cfg_if.sink         s_cfg
);

    dds_pkg::t_cfg                cfg;
    dds_pkg::t_mode_force         mforce;
    logic                         cfg_wr;

    logic                         r_s1_valid;
    logic                         r_s1_dark;
    logic [dds_pkg::MODE_W-1:0]   r_mode;
    logic [dds_pkg::MODE_W-1:0]   n_mode;
    logic [dds_pkg::TIMER_W-1:0]  r_timer;
    logic [dds_pkg::TIMER_W-1:0]  n_timer;
    logic                         step_lit;
    logic [dds_pkg::MODE_W-1:0]   step_mode;
    logic [dds_pkg::TIMER_W-1:0]  step_timer;
    logic                         r_out_valid;
    logic                         r_out_lit;
    logic [dds_pkg::MODE_W-1:0]   r_out_mode;
    logic                         out_load;
    logic                         advance;

    assign s_cfg.ready = 1'b1;
    assign cfg_wr      = s_cfg.valid;

    dds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (s_cfg.index),
        .i_data  (s_cfg.data),
        .o_cfg   (cfg),
        .o_force (mforce)
    );

    dds_step u_step (
        .i_mode    (r_mode),
        .i_timer   (r_timer),
        .i_is_dark (r_s1_dark),
        .i_cfg     (cfg),
        .o_mode    (step_mode),
        .o_timer   (step_timer),
        .o_lit     (step_lit)
    );

    assign out_load    = !r_out_valid || m_out.ready;
    assign advance     = r_s1_valid && out_load;
    assign s_in.ready  = !r_s1_valid || out_load;

    always_comb begin
        n_mode  = r_mode;
        n_timer = r_timer;
        if (mforce.force_mode) begin
            n_mode = mforce.enable ? dds_pkg::MODE_WATCHING : dds_pkg::MODE_DISABLED;
        end else if (advance) begin
            n_mode  = step_mode;
            n_timer = step_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= dds_pkg::MODE_WATCHING;
            r_timer     <= '0;
        end else begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
            if (s_in.ready) begin
                r_s1_valid <= s_in.valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_s1_dark <= s_in.is_dark;
        end
        if (advance) begin
            r_out_lit  <= step_lit;
            r_out_mode <= step_mode;
        end
    end

    assign m_out.valid     = r_out_valid;
    assign m_out.lights_on = r_out_lit;
    assign m_out.mode_now  = r_out_mode;

    a_disable_forces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && s_cfg.index == dds_pkg::REG_ENABLED && !s_cfg.data[0])
        |=> (r_mode == dds_pkg::MODE_DISABLED))
        else $error("enable write of zero did not force disabled mode");

    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == dds_pkg::MODE_DISABLED && !cfg_wr)
        |=> (r_mode == dds_pkg::MODE_DISABLED && $stable(r_timer)))
        else $error("disabled mode changed without a register write");

    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_dark)))
        else $error("stalled tick lost");

    a_dark_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && (m_out.mode_now == dds_pkg::MODE_WATCHING ||
                         m_out.mode_now == dds_pkg::MODE_ON_DELAY))
        |-> !m_out.lights_on)
        else $error("lamps lit while watching or in on-delay");

endmodule

`default_nettype wire

### design/dds_cfg.sv
// ----------------------------------------------------------------------------
// dds_cfg
// Register file of the sequencer; flags an enable write to force the mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_wr,
    input  wire [dds_pkg::CIDX_W-1:0]    i_index,
    input  wire [dds_pkg::CDATA_W-1:0]   i_data,
    output dds_pkg::t_cfg                o_cfg,
    output dds_pkg::t_mode_force         o_force
);

    dds_pkg::t_cfg r_cfg;
    dds_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                dds_pkg::REG_ON_DELAY:    n_cfg.on_delay    = i_data[dds_pkg::DELAY_W-1:0];
                dds_pkg::REG_OFF_DELAY:   n_cfg.off_delay   = i_data[dds_pkg::DELAY_W-1:0];
                dds_pkg::REG_ON_DURATION: n_cfg.on_duration = i_data[dds_pkg::TIMER_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg              = r_cfg;
    assign o_force.force_mode = i_wr && (i_index == dds_pkg::REG_ENABLED);
    assign o_force.enable     = i_data[0];

endmodule

`default_nettype wire

### design/dds_step.sv
// ----------------------------------------------------------------------------
// dds_step
// Next mode, next minute timer and lamp state for one minute tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_step (
    input  wire [dds_pkg::MODE_W-1:0]    i_mode,
    input  wire [dds_pkg::TIMER_W-1:0]   i_timer,
    input  wire                          i_is_dark,
    input  dds_pkg::t_cfg                i_cfg,
    output logic [dds_pkg::MODE_W-1:0]   o_mode,
    output logic [dds_pkg::TIMER_W-1:0]  o_timer,
    output logic                         o_lit
);

    logic                         timer_nz;
    logic [dds_pkg::TIMER_W-1:0]  timer_dec;
    logic [dds_pkg::TIMER_W-1:0]  on_delay_ext;

    assign timer_nz     = (i_timer != '0);
    assign timer_dec    = i_timer - dds_pkg::TIMER_W'(1);
    assign on_delay_ext = dds_pkg::TIMER_W'(i_cfg.on_delay);

    always_comb begin
        o_mode  = i_mode;
        o_timer = i_timer;
        case (i_mode)
            dds_pkg::MODE_WATCHING: begin
                if (i_is_dark) begin
                    o_mode  = dds_pkg::MODE_ON_DELAY;
                    o_timer = (on_delay_ext != '0) ? on_delay_ext - dds_pkg::TIMER_W'(1)
                                                   : on_delay_ext;
                end
            end
            dds_pkg::MODE_ON_DELAY: begin
                if (i_timer > dds_pkg::TIMER_W'(1)) begin
                    o_timer = timer_dec;
                end else begin
                    o_timer = i_cfg.on_duration;
                    o_mode  = dds_pkg::MODE_DARK;
                end
            end
            dds_pkg::MODE_DARK: begin
                if (!i_is_dark) begin
                    o_mode  = dds_pkg::MODE_OFF_DELAY;
                    o_timer = dds_pkg::TIMER_W'(i_cfg.off_delay);
                end else if (timer_nz) begin
                    o_timer = timer_dec;
                end
            end
            dds_pkg::MODE_OFF_DELAY: begin
                if (timer_nz) begin
                    o_timer = timer_dec;
                end else begin
                    o_mode = dds_pkg::MODE_WATCHING;
                end
            end
            default: begin
                o_mode  = i_mode;
                o_timer = i_timer;
            end
        endcase
    end

    assign o_lit = (o_mode == dds_pkg::MODE_DISABLED) ||
                   (((o_mode == dds_pkg::MODE_DARK) || (o_mode == dds_pkg::MODE_OFF_DELAY)) &&
                    (o_timer != '0));

endmodule

`default_nettype wire

### tb/dusk_dawn_light_sequencer_test.sv
// ----------------------------------------------------------------------------
// dusk_dawn_light_sequencer_test
// Drives minute ticks with random dark/daylight runs through the sequencer,
// reprograms the delay, duration and enable registers between quiet phases,
// and checks every lights_on/mode_now result against a local mode/timer
// predictor, with random idle cycles and output stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dusk_dawn_light_sequencer_test;

    typedef struct packed {
        logic                       lights_on;
        logic [dds_pkg::MODE_W-1:0] mode_now;
    } t_lamp_state;

    logic i_clk;
    logic i_rst_n;

    dds_item_if   tick_if();
    dds_result_if lamp_if();
    dds_cfg_if    cfg_if();

    dusk_dawn_light_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (tick_if),
        .m_out   (lamp_if),
        .s_cfg   (cfg_if)
    );

    logic [dds_pkg::MODE_W-1:0]  seq_mode     = dds_pkg::MODE_WATCHING;
    logic [dds_pkg::TIMER_W-1:0] minute_timer = '0;
    logic                        seq_enabled  = 1'b1;
    dds_pkg::t_cfg               delays       = '0;

    bit          pending_dark[$];
    t_lamp_state expected_lamps[$];
    int          ticks_accepted = 0;
    int          lamps_checked  = 0;
    int          error_count    = 0;
    int          ticks_queued   = 0;

    function automatic t_lamp_state advance_sequencer(input logic dark);
        t_lamp_state lamp;
        case (seq_mode)
            dds_pkg::MODE_WATCHING: begin
                if (dark) begin
                    seq_mode     = dds_pkg::MODE_ON_DELAY;
                    minute_timer = dds_pkg::TIMER_W'(delays.on_delay);
                    if (minute_timer != '0)
                        minute_timer = minute_timer - 1'b1;
                end
            end
            dds_pkg::MODE_ON_DELAY: begin
                if (minute_timer > 1) begin
                    minute_timer = minute_timer - 1'b1;
                end else begin
                    minute_timer = delays.on_duration;
                    seq_mode     = dds_pkg::MODE_DARK;
                end
            end
            dds_pkg::MODE_DARK: begin
                if (minute_timer != '0)
                    minute_timer = minute_timer - 1'b1;
                if (!dark) begin
                    seq_mode     = dds_pkg::MODE_OFF_DELAY;
                    minute_timer = dds_pkg::TIMER_W'(delays.off_delay);
                end
            end
            dds_pkg::MODE_OFF_DELAY: begin
                if (minute_timer != '0)
                    minute_timer = minute_timer - 1'b1;
                else
                    seq_mode = dds_pkg::MODE_WATCHING;
            end
            default: ;
        endcase
        lamp.lights_on = (seq_mode == dds_pkg::MODE_DISABLED) ||
                         ((seq_mode == dds_pkg::MODE_DARK ||
                           seq_mode == dds_pkg::MODE_OFF_DELAY) &&
                          minute_timer != '0);
        lamp.mode_now  = seq_mode;
        return lamp;
    endfunction

    function automatic void apply_register(input logic [dds_pkg::CIDX_W-1:0] idx,
                                           input logic [dds_pkg::CDATA_W-1:0] value);
        case (idx)
            dds_pkg::REG_ENABLED: begin
                seq_enabled = value[0];
                seq_mode    = value[0] ? dds_pkg::MODE_WATCHING : dds_pkg::MODE_DISABLED;
            end
            dds_pkg::REG_ON_DELAY:    delays.on_delay    = value[dds_pkg::DELAY_W-1:0];
            dds_pkg::REG_OFF_DELAY:   delays.off_delay   = value[dds_pkg::DELAY_W-1:0];
            dds_pkg::REG_ON_DURATION: delays.on_duration = value[dds_pkg::TIMER_W-1:0];
            default: ;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid   <= 1'b0;
            tick_if.is_dark <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                expected_lamps.push_back(advance_sequencer(tick_if.is_dark));
                ticks_accepted++;
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (pending_dark.size() != 0 &&
                    ((ticks_accepted >= 250 && ticks_accepted < 400) ||
                     $urandom_range(0, 99) >= 29)) begin
                    tick_if.valid   <= 1'b1;
                    tick_if.is_dark <= pending_dark.pop_front();
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : lamp_monitor
        t_lamp_state want;
        if (!i_rst_n) begin
            lamp_if.ready <= 1'b0;
        end else begin
            if (lamp_if.valid && lamp_if.ready) begin
                if (expected_lamps.size() == 0) begin
                    $error("unexpected result: lights_on=%0b mode_now=%0d",
                           lamp_if.lights_on, lamp_if.mode_now);
                    error_count++;
                end else begin
                    want = expected_lamps.pop_front();
                    if (lamp_if.lights_on !== want.lights_on) begin
                        $error("lights_on mismatch: expected %0b, actual %0b",
                               want.lights_on, lamp_if.lights_on);
                        error_count++;
                    end
                    if (lamp_if.mode_now !== want.mode_now) begin
                        $error("mode_now mismatch: expected %0d, actual %0d",
                               want.mode_now, lamp_if.mode_now);
                        error_count++;
                    end
                    lamps_checked++;
                end
            end
            lamp_if.ready <= (lamps_checked >= 250 && lamps_checked < 400) ||
                             $urandom_range(0, 99) >= 29;
        end
    end

    task automatic write_register(input logic [dds_pkg::CIDX_W-1:0] idx,
                                  input logic [dds_pkg::CDATA_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_register(idx, value);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_dark.size() != 0 || tick_if.valid || expected_lamps.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_ticks(input bit dark, input int count);
        repeat (count) pending_dark.push_back(dark);
        ticks_queued += count;
    endtask

    function automatic logic [dds_pkg::DELAY_W-1:0] pick_delay();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? {dds_pkg::DELAY_W{1'b1}} : '0;
        return dds_pkg::DELAY_W'($urandom_range(0, 6));
    endfunction

    function automatic logic [dds_pkg::TIMER_W-1:0] pick_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return $urandom_range(0, 1) ? {dds_pkg::TIMER_W{1'b1}} : '0;
        if (roll < 15)
            return dds_pkg::TIMER_W'($urandom_range(0, 65535));
        return dds_pkg::TIMER_W'($urandom_range(0, 12));
    endfunction

    initial begin : stimulus
        int roll;
        int segments;
        tick_if.valid   = 1'b0;
        tick_if.is_dark = 1'b0;
        lamp_if.ready   = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: every delay zero
        queue_ticks(1'b0, 1);
        queue_ticks(1'b1, 2);
        queue_ticks(1'b0, 2);
        wait_drained();

        write_register(dds_pkg::REG_ON_DELAY, dds_pkg::CDATA_W'(2));
        write_register(dds_pkg::REG_OFF_DELAY, dds_pkg::CDATA_W'(2));
        write_register(dds_pkg::REG_ON_DURATION, dds_pkg::CDATA_W'(3));
        queue_ticks(1'b1, 6);
        queue_ticks(1'b0, 4);
        wait_drained();

        write_register(dds_pkg::REG_ENABLED, dds_pkg::CDATA_W'(0));
        queue_ticks(1'b1, 1);
        queue_ticks(1'b0, 1);
        wait_drained();
        write_register(dds_pkg::REG_ENABLED, dds_pkg::CDATA_W'(1));

        write_register(dds_pkg::REG_ON_DELAY,
                       {dds_pkg::CDATA_W{1'b1}} >> (dds_pkg::CDATA_W - dds_pkg::DELAY_W));
        write_register(dds_pkg::REG_OFF_DELAY,
                       {dds_pkg::CDATA_W{1'b1}} >> (dds_pkg::CDATA_W - dds_pkg::DELAY_W));
        write_register(dds_pkg::REG_ON_DURATION, {dds_pkg::CDATA_W{1'b1}});
        queue_ticks(1'b1, 3);
        wait_drained();

        // force watching mid on-delay, timer keeps its count
        write_register(dds_pkg::REG_ENABLED, dds_pkg::CDATA_W'(1));
        queue_ticks(1'b0, 1);
        queue_ticks(1'b1, 1);

        while (ticks_queued < 720) begin
            wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 12)
                write_register(dds_pkg::REG_ENABLED, dds_pkg::CDATA_W'(0));
            else if (roll < 45 || !seq_enabled)
                write_register(dds_pkg::REG_ENABLED, dds_pkg::CDATA_W'(1));
            if ($urandom_range(0, 1))
                write_register(dds_pkg::REG_ON_DELAY, dds_pkg::CDATA_W'(pick_delay()));
            if ($urandom_range(0, 1))
                write_register(dds_pkg::REG_OFF_DELAY, dds_pkg::CDATA_W'(pick_delay()));
            if ($urandom_range(0, 1))
                write_register(dds_pkg::REG_ON_DURATION, dds_pkg::CDATA_W'(pick_duration()));
            segments = $urandom_range(2, 8);
            repeat (segments) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 6))
                        queue_ticks(1'($urandom_range(0, 1)), 1);
                end else begin
                    queue_ticks(1'b1, $urandom_range(1, 15));
                    queue_ticks(1'b0, $urandom_range(1, 10));
                end
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (error_count == 0 && expected_lamps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
